[rtl/dcm_pkg.sv]
// ----------------------------------------------------------------------------
// dcm_pkg
// Shared types, widths and codes for the dc motor rk4 step core.
// ----------------------------------------------------------------------------
package dcm_pkg;

  // field and datapath widths
  localparam int Q_W       = 32;   // signed q16.16 values
  localparam int COEF_W    = 31;   // unsigned q15.16 coefficients
  localparam int STEP_W    = 24;   // unsigned q0.24 step size
  localparam int PROD_W    = 64;   // multiplier product
  localparam int TERM_W    = 48;   // product rounded to q32.16
  localparam int SUM_W     = 50;   // exact sums ahead of saturation
  localparam int INC_W     = 40;   // h*k rounded to q24.16
  localparam int ACC_W     = 60;   // exact weighted sum of h*k
  localparam int DIV_W     = 36;   // divide-by-six dividend
  localparam int QUO_W     = 33;   // divide-by-six quotient
  localparam int DIV_BITS  = 4;    // dividend bits retired per cycle
  localparam int DIV_STEPS = DIV_W / DIV_BITS;
  localparam int LANES     = 2;    // current and speed

  // sequencer state
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } state_t;

  // micro-ops of one rk4 stage, in issue order
  typedef enum logic [2:0] {
    OP_RA_I,
    OP_GAFL_W,
    OP_INVL_U,
    OP_GAFJ_I,
    OP_BJ_W,
    OP_INVJ_T,
    OP_H_KI,
    OP_H_KW
  } op_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_RA_OVER_LA,
    REG_GAF_OVER_LA,
    REG_INV_LA,
    REG_GAF_OVER_J,
    REG_B_OVER_J,
    REG_INV_J,
    REG_STEP_SIZE
  } reg_idx_t;

  // clamp an exact sum to the signed 32-bit range
  function automatic logic signed [Q_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] max_v;
    logic signed [SUM_W-1:0] min_v;
    max_v = SUM_W'(64'sh7fff_ffff);
    min_v = -max_v - SUM_W'(1);
    if (v > max_v) begin
      sat32 = {1'b0, {(Q_W-1){1'b1}}};
    end else if (v < min_v) begin
      sat32 = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      sat32 = v[Q_W-1:0];
    end
  endfunction

endpackage

[rtl/dcm_div6.sv]
// ----------------------------------------------------------------------------
// dcm_div6
// Two-lane serial divider by six, DIV_BITS dividend bits per cycle.
// ----------------------------------------------------------------------------
module dcm_div6 import dcm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend [LANES],
  output logic             done,
  output logic [QUO_W-1:0] quotient [LANES]
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);
  localparam logic [3:0] DIVISOR = 4'd6;

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [2:0]       rem [LANES];
  logic [DIV_W-1:0] sh [LANES];
  logic [2:0]       rem_next [LANES];
  logic [DIV_W-1:0] sh_next [LANES];

  // restoring division, DIV_BITS bits per lane each cycle
  always_comb begin
    logic [3:0]       t;
    logic [2:0]       r;
    logic [DIV_W-1:0] s;
    for (int l = 0; l < LANES; l++) begin
      r = rem[l];
      s = sh[l];
      for (int k = 0; k < DIV_BITS; k++) begin
        t = {r, s[DIV_W-1]};
        if (t >= DIVISOR) begin
          r = 3'(t - DIVISOR);
          s = {s[DIV_W-2:0], 1'b1};
        end else begin
          r = t[2:0];
          s = {s[DIV_W-2:0], 1'b0};
        end
      end
      rem_next[l] = r;
      sh_next[l]  = s;
    end
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out, quotient shifts in
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (start) begin
        rem[l] <= '0;
        sh[l]  <= dividend[l];
      end else if (active) begin
        rem[l] <= rem_next[l];
        sh[l]  <= sh_next[l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quotient[l] = sh[l][QUO_W-1:0];
    end
  end

endmodule

[rtl/dc_motor_rk4_step_core.sv]
// ----------------------------------------------------------------------------
// dc_motor_rk4_step_core
// One rk4 step of a dc motor model per item, on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// each item runs 32 multiplies through the shared multiplier (8 per rk4 stage),
// then the drain and load states and the divide-by-six of the final update;
// a new input item is accepted only once the last one reaches the output register
// reset (rst, synchronous): coefficients, step size and motor state go to zero
module dc_motor_rk4_step_core import dcm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] motor_voltage, [63:32] load_torque
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // [31:0] rotor_current, [63:32] angular_velocity
);

  // configuration registers
  logic [COEF_W-1:0] ra_over_la;
  logic [COEF_W-1:0] gaf_over_la;
  logic [COEF_W-1:0] inv_la;
  logic [COEF_W-1:0] gaf_over_j;
  logic [COEF_W-1:0] b_over_j;
  logic [COEF_W-1:0] inv_j;
  logic [STEP_W-1:0] step_size;

  // motor state and working registers
  logic signed [Q_W-1:0]    current_state;
  logic signed [Q_W-1:0]    speed_state;
  logic signed [Q_W-1:0]    volt;
  logic signed [Q_W-1:0]    torque;
  logic signed [Q_W-1:0]    ia;
  logic signed [Q_W-1:0]    wa;
  logic signed [Q_W-1:0]    ki;
  logic signed [Q_W-1:0]    kw;
  logic signed [SUM_W-1:0]  dsum;
  logic signed [ACC_W-1:0]  acc_i;
  logic signed [ACC_W-1:0]  acc_w;

  // sequencer
  state_t     state;
  state_t     state_next;
  logic [4:0] cnt;
  op_t        issue_op;
  logic [1:0] issue_stage;
  logic       issue;
  logic       div_start;
  logic       out_load;
  logic       in_accept;
  logic       cfg_write;

  // multiplier stage
  logic signed [Q_W-1:0]    mul_a;
  logic signed [Q_W-1:0]    mul_b;
  logic signed [PROD_W-1:0] prod;
  op_t                      pop;
  logic [1:0]               pstage;
  logic                     pvalid;

  // accumulate stage
  logic signed [PROD_W-1:0] adj16;
  logic signed [PROD_W-1:0] adj25;
  logic signed [PROD_W-1:0] adj24;
  logic signed [SUM_W-1:0]  term_ext;
  logic signed [INC_W-1:0]  inc;
  logic signed [Q_W-1:0]    adv_base;
  logic signed [SUM_W-1:0]  adv_sum;
  logic signed [ACC_W-1:0]  wprod;

  // final update
  logic [ACC_W-1:0]           mag_i;
  logic [ACC_W-1:0]           mag_w;
  logic [ACC_W-1:0]           rnd_i;
  logic [ACC_W-1:0]           rnd_w;
  logic [DIV_W-1:0]           div_in [LANES];
  logic [QUO_W-1:0]           div_q [LANES];
  logic                       div_done;
  logic signed [QUO_W:0]      qs_i;
  logic signed [QUO_W:0]      qs_w;
  logic signed [Q_W-1:0]      current_next;
  logic signed [Q_W-1:0]      speed_next;

  // configuration writes and reads
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ra_over_la  <= '0;
      gaf_over_la <= '0;
      inv_la      <= '0;
      gaf_over_j  <= '0;
      b_over_j    <= '0;
      inv_j       <= '0;
      step_size   <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(paddr[4:2]))
        REG_RA_OVER_LA:  ra_over_la  <= pwdata[COEF_W-1:0];
        REG_GAF_OVER_LA: gaf_over_la <= pwdata[COEF_W-1:0];
        REG_INV_LA:      inv_la      <= pwdata[COEF_W-1:0];
        REG_GAF_OVER_J:  gaf_over_j  <= pwdata[COEF_W-1:0];
        REG_B_OVER_J:    b_over_j    <= pwdata[COEF_W-1:0];
        REG_INV_J:       inv_j       <= pwdata[COEF_W-1:0];
        REG_STEP_SIZE:   step_size   <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_RA_OVER_LA:  prdata = {1'b0, ra_over_la};
      REG_GAF_OVER_LA: prdata = {1'b0, gaf_over_la};
      REG_INV_LA:      prdata = {1'b0, inv_la};
      REG_GAF_OVER_J:  prdata = {1'b0, gaf_over_j};
      REG_B_OVER_J:    prdata = {1'b0, b_over_j};
      REG_INV_J:       prdata = {1'b0, inv_j};
      REG_STEP_SIZE:   prdata = {8'b0, step_size};
      default:         prdata = '0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_RUN;
      ST_RUN:   if (cnt == 5'd31) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_FIN;
      ST_FIN:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    issue     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: s_tready  = 1'b1;
      ST_RUN:  issue     = 1'b1;
      ST_LOAD: div_start = 1'b1;
      ST_FIN:  out_load  = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  assign in_accept   = s_tvalid & s_tready;
  assign issue_op    = op_t'(cnt[2:0]);
  assign issue_stage = cnt[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      pvalid <= 1'b0;
    end else begin
      state  <= state_next;
      pvalid <= issue;
      if (in_accept) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + 5'd1;
      end
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    case (issue_op)
      OP_RA_I:   begin mul_a = signed'({1'b0, ra_over_la});  mul_b = ia;     end
      OP_GAFL_W: begin mul_a = signed'({1'b0, gaf_over_la}); mul_b = wa;     end
      OP_INVL_U: begin mul_a = signed'({1'b0, inv_la});      mul_b = volt;   end
      OP_GAFJ_I: begin mul_a = signed'({1'b0, gaf_over_j});  mul_b = ia;     end
      OP_BJ_W:   begin mul_a = signed'({1'b0, b_over_j});    mul_b = wa;     end
      OP_INVJ_T: begin mul_a = signed'({1'b0, inv_j});       mul_b = torque; end
      OP_H_KI:   begin mul_a = signed'({8'b0, step_size});   mul_b = ki;     end
      default:   begin mul_a = signed'({8'b0, step_size});   mul_b = kw;     end
    endcase
  end

  // multiplier register
  always_ff @(posedge clk) begin
    prod   <= PROD_W'(mul_a) * PROD_W'(mul_b);
    pop    <= issue_op;
    pstage <= issue_stage;
  end

  // rounding half away from zero at the three binary points in use
  always_comb begin
    adj16 = prod + (prod[PROD_W-1] ? 64'sd32767 : 64'sd32768);
    adj25 = prod + (prod[PROD_W-1] ? 64'sd16777215 : 64'sd16777216);
    adj24 = prod + (prod[PROD_W-1] ? 64'sd8388607 : 64'sd8388608);
    term_ext = SUM_W'(signed'(adj16[PROD_W-1:16]));
    if (pstage == 2'd2) begin
      inc = signed'(adj24[PROD_W-1:24]);
    end else begin
      inc = INC_W'(signed'(adj25[PROD_W-1:25]));
    end
    adv_base = (pop == OP_H_KI) ? current_state : speed_state;
    adv_sum  = SUM_W'(adv_base) + SUM_W'(inc);
    if (pstage == 2'd1 || pstage == 2'd2) begin
      wprod = signed'({prod[ACC_W-2:0], 1'b0});
    end else begin
      wprod = signed'(prod[ACC_W-1:0]);
    end
  end

  // derivative sums, stage points and weighted increment sums
  always_ff @(posedge clk) begin
    if (in_accept) begin
      volt   <= signed'(s_tdata[31:0]);
      torque <= signed'(s_tdata[63:32]);
      ia     <= current_state;
      wa     <= speed_state;
    end else if (pvalid) begin
      case (pop)
        OP_RA_I:   dsum <= -term_ext;
        OP_GAFL_W: dsum <= dsum - term_ext;
        OP_INVL_U: ki   <= sat32(dsum + term_ext);
        OP_GAFJ_I: dsum <= term_ext;
        OP_BJ_W:   dsum <= dsum - term_ext;
        OP_INVJ_T: kw   <= sat32(dsum + term_ext);
        OP_H_KI: begin
          if (pstage != 2'd3) ia <= sat32(adv_sum);
          acc_i <= (pstage == 2'd0) ? wprod : acc_i + wprod;
        end
        default: begin
          if (pstage != 2'd3) wa <= sat32(adv_sum);
          acc_w <= (pstage == 2'd0) ? wprod : acc_w + wprod;
        end
      endcase
    end
  end

  // magnitude, offset by 3*2^24 so the quotient rounds, shifted down by 24 into the divide by six
  always_comb begin
    mag_i = acc_i[ACC_W-1] ? ACC_W'(-acc_i) : ACC_W'(acc_i);
    mag_w = acc_w[ACC_W-1] ? ACC_W'(-acc_w) : ACC_W'(acc_w);
    rnd_i = mag_i + ACC_W'(50331648);
    rnd_w = mag_w + ACC_W'(50331648);
    div_in[0] = rnd_i[ACC_W-1:24];
    div_in[1] = rnd_w[ACC_W-1:24];
  end

  dcm_div6 u_div6 (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_in),
    .done     (div_done),
    .quotient (div_q)
  );

  // new state from the signed quotient
  always_comb begin
    qs_i = acc_i[ACC_W-1] ? -signed'({1'b0, div_q[0]}) : signed'({1'b0, div_q[0]});
    qs_w = acc_w[ACC_W-1] ? -signed'({1'b0, div_q[1]}) : signed'({1'b0, div_q[1]});
    current_next = sat32(SUM_W'(current_state) + SUM_W'(qs_i));
    speed_next   = sat32(SUM_W'(speed_state) + SUM_W'(qs_w));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_state <= '0;
      speed_state   <= '0;
    end else if (out_load) begin
      current_state <= current_next;
      speed_state   <= speed_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {speed_next, current_next};
    end
  end

endmodule
